[hw/rtl/icl_pkg.sv]
// ----------------------------------------------------------------------------
// icl_pkg
// Shared types and constants of the ichimoku cloud lines block.
// ----------------------------------------------------------------------------
package icl_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONV_PERIOD = 2'd0,
    CFG_BASE_PERIOD = 2'd1,
    CFG_SPANB_PERIOD = 2'd2,
    CFG_LAG_SHIFT   = 2'd3
  } cfg_idx_t;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] CONV_PERIOD_RST  = 7'd9;
  localparam logic [CFG_DATA_W-1:0] BASE_PERIOD_RST  = 7'd26;
  localparam logic [CFG_DATA_W-1:0] SPANB_PERIOD_RST = 7'd52;
  localparam logic [CFG_DATA_W-1:0] LAG_SHIFT_RST    = 7'd26;

  // saturating bar counter
  localparam int             BARS_W   = 8;
  localparam logic [BARS_W-1:0] BARS_MAX = 8'hFF;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // per-bar classification made by the front
  typedef struct packed {
    logic conv_ok;   // conversion window full
    logic base_ok;   // base window full
    logic spanb_ok;  // span b window full
    logic dly_ok;    // bar base_period back exists
    logic lag_ok;    // bar lag_shift back exists
  } icl_flags_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_MID,
    BK_SPAN
  } bk_state_t;

endpackage

[hw/rtl/icl_if.sv]
// ----------------------------------------------------------------------------
// icl_if
// Valid/ready channels of the ichimoku cloud lines block: price bars in,
// line results out, and the configuration write channel.
// ----------------------------------------------------------------------------

// price bar channel
interface icl_bar_if #(
  parameter int PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] bar_high;
  logic [PRICE_BITS-1:0] bar_low;
  logic [PRICE_BITS-1:0] bar_close;

  modport source (output valid, output bar_high, output bar_low, output bar_close,
                  input ready);
  modport sink (input valid, input bar_high, input bar_low, input bar_close,
                output ready);
endinterface

// line result channel
interface icl_line_if #(
  parameter int PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS+1:0] conversion_line;
  logic                  conversion_valid;
  logic [PRICE_BITS+1:0] base_line;
  logic                  base_valid;
  logic [PRICE_BITS+1:0] leading_a;
  logic                  leading_a_valid;
  logic [PRICE_BITS+1:0] leading_b;
  logic                  leading_b_valid;
  logic [PRICE_BITS-1:0] lagging_close;
  logic                  lagging_valid;

  modport source (output valid, output conversion_line, output conversion_valid,
                  output base_line, output base_valid, output leading_a,
                  output leading_a_valid, output leading_b, output leading_b_valid,
                  output lagging_close, output lagging_valid, input ready);
  modport sink (input valid, input conversion_line, input conversion_valid,
                input base_line, input base_valid, input leading_a,
                input leading_a_valid, input leading_b, input leading_b_valid,
                input lagging_close, input lagging_valid, output ready);
endinterface

// configuration write channel
interface icl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [icl_pkg::CFG_IDX_W-1:0]    index;
  logic [icl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ichimoku_cloud_lines_core.sv]
// ----------------------------------------------------------------------------
// ichimoku_cloud_lines_core
// Ichimoku cloud lines over a stream of price bars, one result per bar.
// ----------------------------------------------------------------------------
// in_ch takes one price bar (high, low, close in ticks) per transaction and
// out_ch returns one transaction per bar: conversion and base lines, both
// leading spans delayed by the base period and the lagging close, each with
// its own valid flag; lines are in quarter ticks.
// cfg_ch writes the four period/shift registers; it is always ready and is
// meant to be used only while no bar is in flight.
// In the back end a bar is stored in the high/low ring, then the walk does one
// read per older ring entry (the single read port of the high/low ring sets
// this) and then folds the last read, then the midpoints are formed, and
// last the delay store and the output register are written.
// A two-entry command queue lets new bars be taken while the back end works.
// Reset clears the write slot, the bar counter, the queue and the output
// valid, and restores the register defaults; stores need no clearing.
// When out_ch stalls the result waits in the output register, the back end
// holds its next result, and in_ch drops ready once the queue is full.
// ----------------------------------------------------------------------------
module ichimoku_cloud_lines_core #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  icl_bar_if.sink    in_ch,
  icl_cfg_if.sink    cfg_ch,
  icl_line_if.source out_ch
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int KW    = AW + 1;
  localparam int CMD_W = $bits(icl_pkg::icl_flags_t) + AW + 4 * KW + 3 * PRICE_BITS;

  logic                q_ready, q_push, q_valid, q_pop;
  logic [CMD_W-1:0]    q_wdata, q_rdata;

  icl_pkg::icl_flags_t f_flags, b_flags;
  logic [AW-1:0]       f_ws, b_ws;
  logic [KW-1:0]       f_cp, f_bp, f_sp, f_maxp;
  logic [KW-1:0]       b_cp, b_bp, b_sp, b_maxp;
  logic [PRICE_BITS-1:0] f_high, f_low, f_close;
  logic [PRICE_BITS-1:0] b_high, b_low, b_close;

  // front: registers, slot, classification
  icl_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .cmd_flags (f_flags),
    .cmd_ws    (f_ws),
    .cmd_cp    (f_cp),
    .cmd_bp    (f_bp),
    .cmd_sp    (f_sp),
    .cmd_maxp  (f_maxp),
    .cmd_high  (f_high),
    .cmd_low   (f_low),
    .cmd_close (f_close)
  );

  // command word packing
  assign q_wdata = {f_flags, f_ws, f_cp, f_bp, f_sp, f_maxp, f_high, f_low, f_close};
  assign {b_flags, b_ws, b_cp, b_bp, b_sp, b_maxp, b_high, b_low, b_close} = q_rdata;

  icl_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  // back: window walk, lines, delay store, output register
  icl_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cmd_flags (b_flags),
    .cmd_ws    (b_ws),
    .cmd_cp    (b_cp),
    .cmd_bp    (b_bp),
    .cmd_sp    (b_sp),
    .cmd_maxp  (b_maxp),
    .cmd_high  (b_high),
    .cmd_low   (b_low),
    .cmd_close (b_close),
    .out_ch    (out_ch)
  );

endmodule

[hw/rtl/icl_front.sv]
// ----------------------------------------------------------------------------
// icl_front
// Holds the configuration registers, the write slot and the bar counter.
// Accepts price bars and classifies each one into a command for the back end.
// ----------------------------------------------------------------------------
module icl_front #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  icl_bar_if.sink                            in_ch,
  icl_cfg_if.sink                            cfg_ch,
  input  logic                               q_ready,
  output logic                               q_push,
  output icl_pkg::icl_flags_t                cmd_flags,
  output logic [$clog2(MAX_WINDOW)-1:0]      cmd_ws,
  output logic [$clog2(MAX_WINDOW):0]        cmd_cp,
  output logic [$clog2(MAX_WINDOW):0]        cmd_bp,
  output logic [$clog2(MAX_WINDOW):0]        cmd_sp,
  output logic [$clog2(MAX_WINDOW):0]        cmd_maxp,
  output logic [PRICE_BITS-1:0]              cmd_high,
  output logic [PRICE_BITS-1:0]              cmd_low,
  output logic [PRICE_BITS-1:0]              cmd_close
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int KW = AW + 1;

  logic [icl_pkg::CFG_DATA_W-1:0] conv_per_r, conv_per_nxt;
  logic [icl_pkg::CFG_DATA_W-1:0] base_per_r, base_per_nxt;
  logic [icl_pkg::CFG_DATA_W-1:0] spanb_per_r, spanb_per_nxt;
  logic [icl_pkg::CFG_DATA_W-1:0] lag_r, lag_nxt;
  logic [AW-1:0]                  ws_r, ws_nxt;
  logic [icl_pkg::BARS_W-1:0]     bars_r, bars_nxt;
  logic [icl_pkg::BARS_W-1:0]     cnt;
  logic [KW-1:0]                  cp, bp, sp, mx;
  logic                           accept;

  // period of zero acts as one, long periods stop at the ring depth
  function automatic logic [KW-1:0] clamp_per(input logic [icl_pkg::CFG_DATA_W-1:0] raw);
    logic [KW-1:0] res;
    if (raw == '0) begin
      res = KW'(1);
    end else if (int'(raw) > MAX_WINDOW) begin
      res = KW'(MAX_WINDOW);
    end else begin
      res = KW'(raw);
    end
    return res;
  endfunction

  assign accept        = in_ch.valid & q_ready;
  assign in_ch.ready   = q_ready;
  assign cfg_ch.ready  = 1'b1;
  assign q_push        = accept;

  // classification of the bar at the port
  always_comb begin
    cp  = clamp_per(conv_per_r);
    bp  = clamp_per(base_per_r);
    sp  = clamp_per(spanb_per_r);
    mx  = (cp > bp) ? cp : bp;
    mx  = (sp > mx) ? sp : mx;
    cnt = (bars_r == icl_pkg::BARS_MAX) ? icl_pkg::BARS_MAX : bars_r + 1'b1;

    cmd_flags.conv_ok  = int'(cnt) >= int'(cp);
    cmd_flags.base_ok  = int'(cnt) >= int'(bp);
    cmd_flags.spanb_ok = int'(cnt) >= int'(sp);
    cmd_flags.dly_ok   = int'(bars_r) >= int'(bp);
    cmd_flags.lag_ok   = int'(bars_r) >= int'(lag_r);

    cmd_ws    = ws_r;
    cmd_cp    = cp;
    cmd_bp    = bp;
    cmd_sp    = sp;
    cmd_maxp  = mx;
    cmd_high  = in_ch.bar_high;
    cmd_low   = in_ch.bar_low;
    cmd_close = in_ch.bar_close;
  end

  // slot and counter advance per accepted bar, register writes
  always_comb begin
    ws_nxt        = ws_r;
    bars_nxt      = bars_r;
    conv_per_nxt  = conv_per_r;
    base_per_nxt  = base_per_r;
    spanb_per_nxt = spanb_per_r;
    lag_nxt       = lag_r;
    if (accept) begin
      ws_nxt   = (int'(ws_r) == MAX_WINDOW - 1) ? '0 : ws_r + 1'b1;
      bars_nxt = cnt;
    end
    if (cfg_ch.valid) begin
      unique case (icl_pkg::cfg_idx_t'(cfg_ch.index))
        icl_pkg::CFG_CONV_PERIOD:  conv_per_nxt  = cfg_ch.data;
        icl_pkg::CFG_BASE_PERIOD:  base_per_nxt  = cfg_ch.data;
        icl_pkg::CFG_SPANB_PERIOD: spanb_per_nxt = cfg_ch.data;
        icl_pkg::CFG_LAG_SHIFT:    lag_nxt       = cfg_ch.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= '0;
      bars_r      <= '0;
      conv_per_r  <= icl_pkg::CONV_PERIOD_RST;
      base_per_r  <= icl_pkg::BASE_PERIOD_RST;
      spanb_per_r <= icl_pkg::SPANB_PERIOD_RST;
      lag_r       <= icl_pkg::LAG_SHIFT_RST;
    end else begin
      ws_r        <= ws_nxt;
      bars_r      <= bars_nxt;
      conv_per_r  <= conv_per_nxt;
      base_per_r  <= base_per_nxt;
      spanb_per_r <= spanb_per_nxt;
      lag_r       <= lag_nxt;
    end
  end

endmodule

[hw/rtl/icl_queue.sv]
// ----------------------------------------------------------------------------
// icl_queue
// Short first-in first-out command queue between front and back end.
// ----------------------------------------------------------------------------
module icl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = $clog2(icl_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(icl_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [icl_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = int'(count_r) < icl_pkg::QUEUE_DEPTH;
  assign not_empty = count_r != '0;
  assign rdata     = slot_r[rd_ptr_r];
  assign do_push   = push & not_full;
  assign do_pop    = pop & not_empty;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == icl_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == icl_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/icl_back.sv]
// ----------------------------------------------------------------------------
// icl_back
// Executes one bar command: stores the bar in the high/low ring, walks back
// over the ring once for all three window extremes, forms the lines, reads
// and writes the leading span delay store and loads the output register.
// ----------------------------------------------------------------------------
module icl_back #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  icl_pkg::icl_flags_t           cmd_flags,
  input  logic [$clog2(MAX_WINDOW)-1:0] cmd_ws,
  input  logic [$clog2(MAX_WINDOW):0]   cmd_cp,
  input  logic [$clog2(MAX_WINDOW):0]   cmd_bp,
  input  logic [$clog2(MAX_WINDOW):0]   cmd_sp,
  input  logic [$clog2(MAX_WINDOW):0]   cmd_maxp,
  input  logic [PRICE_BITS-1:0]         cmd_high,
  input  logic [PRICE_BITS-1:0]         cmd_low,
  input  logic [PRICE_BITS-1:0]         cmd_close,
  icl_line_if.source                    out_ch
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int KW = AW + 1;
  localparam int PB = PRICE_BITS;
  localparam int LW = PRICE_BITS + 2;
  localparam int DW = 2 * (LW + 1);

  // memories
  logic [2*PB-1:0] ring_mem [MAX_WINDOW];
  logic [DW-1:0]   dly_mem  [MAX_WINDOW];
  logic [2*PB-1:0] ring_q_r;
  logic [DW-1:0]   dly_q_r;

  // sequencer and current command
  icl_pkg::bk_state_t  state_r, state_nxt;
  icl_pkg::icl_flags_t flags_r;
  logic [AW-1:0]       ws_r;
  logic [KW-1:0]       cp_r, bp_r, sp_r, maxp_r;
  logic [PB-1:0]       close_r;
  logic [KW-1:0]       k_r, k_nxt;
  logic [KW-1:0]       kd_r, kd_nxt;
  logic                dv_r, dv_nxt;

  // window extremes
  logic [PB-1:0] chi_r, clo_r, bhi_r, blo_r, shi_r, slo_r;
  logic [PB-1:0] chi_nxt, clo_nxt, bhi_nxt, blo_nxt, shi_nxt, slo_nxt;
  logic [PB-1:0] rd_hi, rd_lo;

  // lines
  logic [LW-1:0] conv_r, base_r, spb_r;
  logic [LW:0]   a_sum;
  logic [LW-1:0] a_now;
  logic          a_ok_now;

  // memory controls
  logic          load_cmd, ring_re, dly_re, fire;
  logic [AW-1:0] ring_addr, dly_addr;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] o_conv_r, o_base_r, o_la_r, o_lb_r;
  logic          o_conv_ok_r, o_base_ok_r, o_la_ok_r, o_lb_ok_r, o_lag_ok_r;
  logic [PB-1:0] o_lag_r;
  logic          dly_a_ok, dly_b_ok;

  // slot k bars before slot ws in the ring
  function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] ws,
                                              input logic [KW-1:0] k);
    logic [KW-1:0] wx;
    logic [KW-1:0] res;
    wx = KW'(ws);
    if (wx >= k) begin
      res = wx - k;
    end else begin
      res = wx + KW'(MAX_WINDOW) - k;
    end
    return res[AW-1:0];
  endfunction

  assign rd_hi    = ring_q_r[2*PB-1:PB];
  assign rd_lo    = ring_q_r[PB-1:0];
  assign a_ok_now = flags_r.conv_ok & flags_r.base_ok;
  assign a_sum    = {1'b0, conv_r} + {1'b0, base_r};
  assign a_now    = a_ok_now ? a_sum[LW:1] : '0;
  assign dly_a_ok = flags_r.dly_ok & dly_q_r[DW-1];
  assign dly_b_ok = flags_r.dly_ok & dly_q_r[LW];

  // next state and controls
  always_comb begin
    state_nxt = state_r;
    load_cmd  = 1'b0;
    q_pop     = 1'b0;
    ring_re   = 1'b0;
    dly_re    = 1'b0;
    fire      = 1'b0;
    k_nxt     = k_r;
    kd_nxt    = kd_r;
    dv_nxt    = dv_r;
    ring_addr = slot_back(ws_r, k_r);
    dly_addr  = slot_back(ws_r, bp_r);
    chi_nxt   = chi_r;
    clo_nxt   = clo_r;
    bhi_nxt   = bhi_r;
    blo_nxt   = blo_r;
    shi_nxt   = shi_r;
    slo_nxt   = slo_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;

    unique case (state_r)
      icl_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          load_cmd = 1'b1;
          k_nxt    = KW'(1);
          dv_nxt   = 1'b0;
          // this bar opens every window
          chi_nxt  = cmd_high;
          bhi_nxt  = cmd_high;
          shi_nxt  = cmd_high;
          clo_nxt  = cmd_low;
          blo_nxt  = cmd_low;
          slo_nxt  = cmd_low;
          state_nxt = icl_pkg::BK_WALK;
        end
      end
      icl_pkg::BK_WALK: begin
        // fold the entry read last cycle
        if (dv_r) begin
          if (kd_r < cp_r) begin
            chi_nxt = (rd_hi > chi_r) ? rd_hi : chi_r;
            clo_nxt = (rd_lo < clo_r) ? rd_lo : clo_r;
          end
          if (kd_r < bp_r) begin
            bhi_nxt = (rd_hi > bhi_r) ? rd_hi : bhi_r;
            blo_nxt = (rd_lo < blo_r) ? rd_lo : blo_r;
          end
          if (kd_r < sp_r) begin
            shi_nxt = (rd_hi > shi_r) ? rd_hi : shi_r;
            slo_nxt = (rd_lo < slo_r) ? rd_lo : slo_r;
          end
        end
        // issue the next read
        if (k_r < maxp_r) begin
          ring_re = 1'b1;
          kd_nxt  = k_r;
          k_nxt   = k_r + 1'b1;
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt    = 1'b0;
          state_nxt = icl_pkg::BK_MID;
        end
      end
      icl_pkg::BK_MID: begin
        dly_re    = 1'b1;
        state_nxt = icl_pkg::BK_SPAN;
      end
      icl_pkg::BK_SPAN: begin
        if (!out_valid_r || out_ch.ready) begin
          fire          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = icl_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = icl_pkg::BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icl_pkg::BK_IDLE;
      k_r         <= '0;
      kd_r        <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      kd_r        <= kd_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command hold and extremes
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      flags_r <= cmd_flags;
      ws_r    <= cmd_ws;
      cp_r    <= cmd_cp;
      bp_r    <= cmd_bp;
      sp_r    <= cmd_sp;
      maxp_r  <= cmd_maxp;
      close_r <= cmd_close;
    end
    chi_r <= chi_nxt;
    clo_r <= clo_nxt;
    bhi_r <= bhi_nxt;
    blo_r <= blo_nxt;
    shi_r <= shi_nxt;
    slo_r <= slo_nxt;
  end

  // midpoints in quarter ticks, zero while the window is short
  always_ff @(posedge clk) begin
    if (state_r == icl_pkg::BK_MID) begin
      conv_r <= flags_r.conv_ok ? {({1'b0, chi_r} + {1'b0, clo_r}), 1'b0} : '0;
      base_r <= flags_r.base_ok ? {({1'b0, bhi_r} + {1'b0, blo_r}), 1'b0} : '0;
      spb_r  <= flags_r.spanb_ok ? {({1'b0, shi_r} + {1'b0, slo_r}), 1'b0} : '0;
    end
  end

  // high/low ring
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      ring_mem[cmd_ws] <= {cmd_high, cmd_low};
    end
    if (ring_re) begin
      ring_q_r <= ring_mem[ring_addr];
    end
  end

  // leading span delay store: {a_ok, a, b_ok, b}
  always_ff @(posedge clk) begin
    if (fire) begin
      dly_mem[ws_r] <= {a_ok_now, a_now, flags_r.spanb_ok, spb_r};
    end
    if (dly_re) begin
      dly_q_r <= dly_mem[dly_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fire) begin
      o_conv_r    <= conv_r;
      o_conv_ok_r <= flags_r.conv_ok;
      o_base_r    <= base_r;
      o_base_ok_r <= flags_r.base_ok;
      o_la_r      <= dly_a_ok ? dly_q_r[DW-2:LW+1] : '0;
      o_la_ok_r   <= dly_a_ok;
      o_lb_r      <= dly_b_ok ? dly_q_r[LW-1:0] : '0;
      o_lb_ok_r   <= dly_b_ok;
      o_lag_r     <= flags_r.lag_ok ? close_r : '0;
      o_lag_ok_r  <= flags_r.lag_ok;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.conversion_line  = o_conv_r;
  assign out_ch.conversion_valid = o_conv_ok_r;
  assign out_ch.base_line        = o_base_r;
  assign out_ch.base_valid       = o_base_ok_r;
  assign out_ch.leading_a        = o_la_r;
  assign out_ch.leading_a_valid  = o_la_ok_r;
  assign out_ch.leading_b        = o_lb_r;
  assign out_ch.leading_b_valid  = o_lb_ok_r;
  assign out_ch.lagging_close    = o_lag_r;
  assign out_ch.lagging_valid    = o_lag_ok_r;

endmodule

[bench/tb_ichimoku_cloud_lines_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ichimoku_cloud_lines_core
// Self-checking bench for the ichimoku cloud lines core: price bars are fed
// through the bar channel, every line result is checked field by field
// against a bar-by-bar predictor, and the four period/shift registers are
// swept across phases, extremes included, with random gaps and stalls on
// both channels and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_ichimoku_cloud_lines_core;

  localparam int          PRICE_BITS   = 32;
  localparam int          LINE_BITS    = PRICE_BITS + 2;
  localparam int          CFG_W        = icl_pkg::CFG_DATA_W;
  localparam int          WINDOW_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_BARS   = 165;
  localparam int unsigned FIRST_BARS   = 125;
  localparam int unsigned DIRECTED     = 25;

  // one line result as seen on the output channel
  typedef struct packed {
    logic [LINE_BITS-1:0]  conversion_line;
    logic                  conversion_valid;
    logic [LINE_BITS-1:0]  base_line;
    logic                  base_valid;
    logic [LINE_BITS-1:0]  leading_a;
    logic                  leading_a_valid;
    logic [LINE_BITS-1:0]  leading_b;
    logic                  leading_b_valid;
    logic [PRICE_BITS-1:0] lagging_close;
    logic                  lagging_valid;
  } line_t;

  // bar-by-bar predictor of the cloud lines and queue of lines still owed
  class cloud_scoreboard;
    bit [PRICE_BITS-1:0] high_hist [WINDOW_DEPTH];
    bit [PRICE_BITS-1:0] low_hist [WINDOW_DEPTH];
    bit [LINE_BITS-1:0]  span_a_hist [WINDOW_DEPTH];
    bit [LINE_BITS-1:0]  span_b_hist [WINDOW_DEPTH];
    bit                  span_a_ok [WINDOW_DEPTH];
    bit                  span_b_ok [WINDOW_DEPTH];
    int unsigned         slot;
    int unsigned         bars_seen;
    bit [CFG_W-1:0]      conv_period;
    bit [CFG_W-1:0]      base_period;
    bit [CFG_W-1:0]      spanb_period;
    bit [CFG_W-1:0]      lag_shift;
    line_t               pending_lines[$];
    int unsigned         mismatches;

    function new();
      slot         = 0;
      bars_seen    = 0;
      mismatches   = 0;
      conv_period  = icl_pkg::CONV_PERIOD_RST;
      base_period  = icl_pkg::BASE_PERIOD_RST;
      spanb_period = icl_pkg::SPANB_PERIOD_RST;
      lag_shift    = icl_pkg::LAG_SHIFT_RST;
    endfunction

    function void write_reg(icl_pkg::cfg_idx_t idx, bit [CFG_W-1:0] val);
      case (idx)
        icl_pkg::CFG_CONV_PERIOD:  conv_period  = val;
        icl_pkg::CFG_BASE_PERIOD:  base_period  = val;
        icl_pkg::CFG_SPANB_PERIOD: spanb_period = val;
        icl_pkg::CFG_LAG_SHIFT:    lag_shift    = val;
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the ring depth saturates
    function int unsigned window_len(bit [CFG_W-1:0] p);
      if (p == 0) return 1;
      if (p > WINDOW_DEPTH) return WINDOW_DEPTH;
      return int'(p);
    endfunction

    // (highest high + lowest low) * 2 over the last p bars ending at ws
    function bit [LINE_BITS-1:0] window_mid(int unsigned ws, int unsigned p);
      bit [PRICE_BITS-1:0] hi;
      bit [PRICE_BITS-1:0] lo;
      bit [LINE_BITS-1:0]  sum;
      int unsigned         idx;
      hi = '0;
      lo = '1;
      for (int unsigned k = 0; k < p; k++) begin
        idx = (ws + WINDOW_DEPTH - k) % WINDOW_DEPTH;
        if (high_hist[idx] > hi) hi = high_hist[idx];
        if (low_hist[idx] < lo) lo = low_hist[idx];
      end
      sum = LINE_BITS'(hi) + LINE_BITS'(lo);
      return sum << 1;
    endfunction

    function int unsigned pending_count();
      return pending_lines.size();
    endfunction

    // predict the line result of one accepted bar
    function void note_bar(bit [PRICE_BITS-1:0] h, bit [PRICE_BITS-1:0] l,
                           bit [PRICE_BITS-1:0] c);
      line_t               want;
      int unsigned         ws;
      int unsigned         cnt;
      int unsigned         cp;
      int unsigned         bp;
      int unsigned         sp;
      int unsigned         rs;
      bit                  a_ok;
      bit                  b_ok;
      bit [LINE_BITS-1:0]  a_now;
      bit [LINE_BITS-1:0]  b_now;
      bit [LINE_BITS:0]    a_sum;
      ws  = slot;
      cnt = (bars_seen < 255) ? bars_seen + 1 : 255;
      cp  = window_len(conv_period);
      bp  = window_len(base_period);
      sp  = window_len(spanb_period);
      high_hist[ws] = h;
      low_hist[ws]  = l;
      want = '0;

      // lines over this bar's windows
      want.conversion_valid = (cnt >= cp);
      want.base_valid       = (cnt >= bp);
      b_ok                  = (cnt >= sp);
      if (want.conversion_valid) want.conversion_line = window_mid(ws, cp);
      if (want.base_valid) want.base_line = window_mid(ws, bp);
      b_now = b_ok ? window_mid(ws, sp) : '0;
      a_ok  = want.conversion_valid && want.base_valid;
      a_sum = {1'b0, want.conversion_line} + {1'b0, want.base_line};
      a_now = a_ok ? a_sum[LINE_BITS:1] : '0;

      // leading spans come from base_period bars back, read before this write
      rs = (ws + WINDOW_DEPTH - bp) % WINDOW_DEPTH;
      if (bars_seen >= bp && span_a_ok[rs]) begin
        want.leading_a_valid = 1'b1;
        want.leading_a       = span_a_hist[rs];
      end
      if (bars_seen >= bp && span_b_ok[rs]) begin
        want.leading_b_valid = 1'b1;
        want.leading_b       = span_b_hist[rs];
      end
      span_a_hist[ws] = a_now;
      span_a_ok[ws]   = a_ok;
      span_b_hist[ws] = b_now;
      span_b_ok[ws]   = b_ok;

      // lagging close belongs to the bar lag_shift back
      if (bars_seen >= lag_shift) begin
        want.lagging_valid = 1'b1;
        want.lagging_close = c;
      end

      pending_lines.push_back(want);
      slot      = (ws + 1) % WINDOW_DEPTH;
      bars_seen = cnt;
    endfunction

    function void report_field(string field, logic [LINE_BITS-1:0] want,
                               logic [LINE_BITS-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    endfunction

    // compare one received line with the oldest prediction
    function void check_line(line_t got);
      line_t want;
      if (pending_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] line result with no bar pending", $time);
        return;
      end
      want = pending_lines.pop_front();
      report_field("conversion_line", want.conversion_line, got.conversion_line);
      report_field("conversion_valid", LINE_BITS'(want.conversion_valid),
                   LINE_BITS'(got.conversion_valid));
      report_field("base_line", want.base_line, got.base_line);
      report_field("base_valid", LINE_BITS'(want.base_valid), LINE_BITS'(got.base_valid));
      report_field("leading_a", want.leading_a, got.leading_a);
      report_field("leading_a_valid", LINE_BITS'(want.leading_a_valid),
                   LINE_BITS'(got.leading_a_valid));
      report_field("leading_b", want.leading_b, got.leading_b);
      report_field("leading_b_valid", LINE_BITS'(want.leading_b_valid),
                   LINE_BITS'(got.leading_b_valid));
      report_field("lagging_close", LINE_BITS'(want.lagging_close),
                   LINE_BITS'(got.lagging_close));
      report_field("lagging_valid", LINE_BITS'(want.lagging_valid),
                   LINE_BITS'(got.lagging_valid));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  icl_bar_if #(.PRICE_BITS(PRICE_BITS))  in_ch ();
  icl_line_if #(.PRICE_BITS(PRICE_BITS)) out_ch ();
  icl_cfg_if                             cfg_ch ();

  ichimoku_cloud_lines_core #(
    .MAX_WINDOW(WINDOW_DEPTH),
    .PRICE_BITS(PRICE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  cloud_scoreboard     sb;
  int unsigned         cycle_count = 0;
  int unsigned         results_seen = 0;
  bit                  steady_source;
  bit                  steady_sink;
  bit [PRICE_BITS-1:0] walk_price;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // cycle count and run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL ichimoku_cloud_lines_core");
    $finish;
  end

  // observe both channels at the rising edge
  always @(posedge clk) begin : monitor_p
    line_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.conversion_line  = out_ch.conversion_line;
        got.conversion_valid = out_ch.conversion_valid;
        got.base_line        = out_ch.base_line;
        got.base_valid       = out_ch.base_valid;
        got.leading_a        = out_ch.leading_a;
        got.leading_a_valid  = out_ch.leading_a_valid;
        got.leading_b        = out_ch.leading_b;
        got.leading_b_valid  = out_ch.leading_b_valid;
        got.lagging_close    = out_ch.lagging_close;
        got.lagging_valid    = out_ch.lagging_valid;
        sb.check_line(got);
        results_seen = results_seen + 1;
      end
      if (in_ch.valid && in_ch.ready)
        sb.note_bar(in_ch.bar_high, in_ch.bar_low, in_ch.bar_close);
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 40);
  endfunction

  // result receiver: random stalls, plus one long hold that backs up the input
  initial begin : sink_p
    int unsigned stall;
    bit          hold_done;
    stall        = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall     = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(steady_sink);
      end
    end
  end

  // one bar transaction, then an optional gap with valid low
  task automatic send_bar(input logic [PRICE_BITS-1:0] h, input logic [PRICE_BITS-1:0] l,
                          input logic [PRICE_BITS-1:0] c, input int unsigned gap);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.bar_high  <= h;
    in_ch.bar_low   <= l;
    in_ch.bar_close <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one register write transaction
  task automatic write_cfg(input icl_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering bars and wait until every line has come back
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // mostly a drifting price series, some noise and some rail values
  task automatic next_bar(output logic [PRICE_BITS-1:0] h, output logic [PRICE_BITS-1:0] l,
                          output logic [PRICE_BITS-1:0] c);
    int unsigned r;
    int unsigned spread;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      if ($urandom_range(0, 1)) walk_price = walk_price + $urandom_range(0, 4096);
      else walk_price = walk_price - $urandom_range(0, 4096);
      if (walk_price < 32'h0100_0000 || walk_price > 32'hFF00_0000)
        walk_price = $urandom_range(32'h0100_0000, 32'hFF00_0000);
      spread = 1 << $urandom_range(0, 16);
      h = walk_price + $urandom_range(0, spread);
      l = walk_price - $urandom_range(0, spread);
      c = l + $urandom_range(0, h - l);
    end else if (r < 9) begin
      h = $urandom;
      l = $urandom;
      c = $urandom;
    end else begin
      h = $urandom_range(0, 1) ? '1 : '0;
      l = $urandom_range(0, 1) ? '1 : '0;
      c = $urandom_range(0, 1) ? '1 : '0;
    end
  endtask

  // register settings of each phase, extremes first, then random
  task automatic pick_setting(input int unsigned ph, output logic [CFG_W-1:0] cp,
                              output logic [CFG_W-1:0] bp,
                              output logic [CFG_W-1:0] sp,
                              output logic [CFG_W-1:0] ls);
    case (ph)
      1: begin cp = 7'd0;   bp = 7'd0;   sp = 7'd0;   ls = 7'd0;   end
      2: begin cp = 7'd64;  bp = 7'd64;  sp = 7'd64;  ls = 7'd64;  end
      3: begin cp = 7'd127; bp = 7'd127; sp = 7'd127; ls = 7'd127; end
      4: begin cp = 7'd1;   bp = 7'd64;  sp = 7'd2;   ls = 7'd0;   end
      5: begin cp = 7'd65;  bp = 7'd1;   sp = 7'd100; ls = 7'd63;  end
      default: begin
        cp = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 20));
        bp = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 20));
        sp = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 20));
        ls = CFG_W'($urandom_range(0, 127));
      end
    endcase
  endtask

  // stimulus and verdict
  initial begin : main_p
    logic [PRICE_BITS-1:0] h;
    logic [PRICE_BITS-1:0] l;
    logic [PRICE_BITS-1:0] c;
    logic [CFG_W-1:0]      cp;
    logic [CFG_W-1:0]      bp;
    logic [CFG_W-1:0]      sp;
    logic [CFG_W-1:0]      ls;
    sb              = new();
    steady_source   = 1'b1;
    steady_sink     = 1'b1;
    walk_price      = 32'h4000_0000;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.bar_high  = '0;
    in_ch.bar_low   = '0;
    in_ch.bar_close = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = icl_pkg::CFG_CONV_PERIOD;
    cfg_ch.data     = '0;

    // reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bars at reset settings: rails, high below low, sliding extremes
    for (int unsigned i = 0; i < DIRECTED; i++) begin
      case (i)
        0: begin h = '1;           l = '0;           c = '1;           end
        1: begin h = '0;           l = '1;           c = '0;           end
        2: begin h = '0;           l = '0;           c = '0;           end
        3: begin h = '1;           l = '1;           c = '1;           end
        4: begin h = 32'hAAAA_AAAA; l = 32'h5555_5555; c = 32'h5555_AAAA; end
        5: begin h = 32'h5555_5555; l = 32'hAAAA_AAAA; c = 32'hAAAA_5555; end
        6: begin h = 32'h8000_0000; l = 32'h7FFF_FFFF; c = 32'h8000_0000; end
        7: begin h = 32'h0000_0001; l = 32'h0000_0001; c = 32'h0000_0001; end
        default: begin
          h = 32'h1000_0000 + i * 32'h0101;
          l = 32'h1000_0000 - i * 32'h0077;
          c = h ^ (i << 3);
        end
      endcase
      send_bar(h, l, c, 0);
    end

    // first phase keeps the reset settings so every valid flag turns on
    steady_source = 1'b0;
    steady_sink   = 1'b0;
    for (int unsigned i = 0; i < FIRST_BARS; i++) begin
      next_bar(h, l, c);
      send_bar(h, l, c, pick_gap(steady_source));
    end
    wait_idle();

    // later phases rewrite all four registers while idle
    for (int unsigned ph = 1; ph < PHASES; ph++) begin
      pick_setting(ph, cp, bp, sp, ls);
      write_cfg(icl_pkg::CFG_CONV_PERIOD, cp);
      write_cfg(icl_pkg::CFG_BASE_PERIOD, bp);
      write_cfg(icl_pkg::CFG_SPANB_PERIOD, sp);
      write_cfg(icl_pkg::CFG_LAG_SHIFT, ls);
      steady_source = (ph == 2) || ($urandom_range(0, 3) == 0);
      steady_sink   = (ph == 2) || ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < PHASE_BARS; i++) begin
        next_bar(h, l, c);
        send_bar(h, l, c, pick_gap(steady_source));
      end
      wait_idle();
    end

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("PASS ichimoku_cloud_lines_core");
    else
      $display("FAIL ichimoku_cloud_lines_core");
    $finish;
  end

endmodule
